// ===== design/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types, widths and side codes for the box collision side detector.
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam int MAX_RECTS  = 64;
   localparam int RECT_IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int RECT_CNT_W = $clog2(MAX_RECTS + 1);

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   // edges and differences are worked at this width so no sum wraps
   localparam int CALC_W  = 18;
   localparam int SIDE_W  = 3;

   localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd0;
   localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd1;
   localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd2;
   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd3;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd4;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]         size_type;
   typedef logic signed [CALC_W-1:0]  calc_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      size_type  width;
      size_type  height;
   } rect_type;

   // moving box with its edges already formed
   typedef struct packed {
      calc_type left;
      calc_type top;
      calc_type right;
      calc_type bottom;
   } query_type;

endpackage

// ===== design/aabb_channels.sv =====
// ----------------------------------------------------------------------------
// aabb_channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface aabb_req_if;
   logic                valid;
   logic                ready;
   logic                func;
   aabb_pkg::coord_type rect_left;
   aabb_pkg::coord_type rect_top;
   aabb_pkg::size_type  rect_width;
   aabb_pkg::size_type  rect_height;

   modport source (output valid, func, rect_left, rect_top, rect_width, rect_height,
                   input ready);
   modport sink   (input valid, func, rect_left, rect_top, rect_width, rect_height,
                   output ready);
endinterface

interface aabb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [aabb_pkg::SIDE_W-1:0]       hit_side;
   aabb_pkg::coord_type               match_left;
   aabb_pkg::coord_type               match_top;
   aabb_pkg::size_type                match_width;
   aabb_pkg::size_type                match_height;
   logic                              add_dropped;

   modport source (output valid, hit_side, match_left, match_top, match_width,
                   match_height, add_dropped, input ready);
   modport sink   (input valid, hit_side, match_left, match_top, match_width,
                   match_height, add_dropped, output ready);
endinterface

// ===== design/aabb_collision_side_detect.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_side_detect
// Stores static boxes and reports the first one a moving box enters, and the side.
// ----------------------------------------------------------------------------
// add item: the box is written in the accept cycle unless the table is full,
//   and its response is loaded in the done state
// query item: one stored box is compared per cycle from the table memory; the scan
//   stops at the first hit or after the last stored box (at most MAX_RECTS, none when empty)
// reset clears the box count, the sequencer and the response valid; table contents stay undefined
//   and are never read before they are written
module aabb_collision_side_detect (
   input  logic        clock,
   input  logic        reset,
   aabb_req_if.sink    req_bus,
   aabb_rsp_if.source  rsp_bus
);
   import aabb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   rect_type rect_mem [MAX_RECTS];
   rect_type rd_data_ff;

   logic [1:0]            state_ff, state_in;
   logic [RECT_CNT_W-1:0] count_ff, count_in;
   logic [RECT_IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   query_type             query_ff, query_in;

   logic [SIDE_W-1:0] res_side_ff, res_side_in;
   rect_type          res_rect_ff, res_rect_in;
   logic              res_drop_ff, res_drop_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIDE_W-1:0] out_side_ff;
   rect_type          out_rect_ff;
   logic              out_drop_ff;

   logic                  accept, out_load, wr_en, rd_en, last_entry;
   logic [RECT_IDX_W-1:0] rd_addr;
   rect_type              req_rect;
   logic [SIDE_W-1:0]     side;

   aabb_side_unit u_side (
      .query (query_ff),
      .entry (rd_data_ff),
      .side  (side)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign last_entry    = (RECT_CNT_W'(cmp_idx_ff) + RECT_CNT_W'(1)) == count_ff;

   assign req_rect.left   = req_bus.rect_left;
   assign req_rect.top    = req_bus.rect_top;
   assign req_rect.width  = req_bus.rect_width;
   assign req_rect.height = req_bus.rect_height;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cmp_idx_in  = cmp_idx_ff;
      query_in    = query_ff;
      res_side_in = res_side_ff;
      res_rect_in = res_rect_ff;
      res_drop_in = res_drop_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = cmp_idx_ff + RECT_IDX_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_side_in = SIDE_NONE;
               res_rect_in = '0;
               res_drop_in = 1'b0;
               if (req_bus.func == FUNC_ADD) begin
                  state_in = ST_DONE;
                  if (count_ff < RECT_CNT_W'(MAX_RECTS)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + RECT_CNT_W'(1);
                  end else begin
                     res_drop_in = 1'b1;
                  end
               end else begin
                  query_in.left   = {{(CALC_W-COORD_W){req_bus.rect_left[COORD_W-1]}},
                                     req_bus.rect_left};
                  query_in.top    = {{(CALC_W-COORD_W){req_bus.rect_top[COORD_W-1]}},
                                     req_bus.rect_top};
                  query_in.right  = query_in.left
                                    + $signed({{(CALC_W-SIZE_W){1'b0}}, req_bus.rect_width});
                  query_in.bottom = query_in.top
                                    + $signed({{(CALC_W-SIZE_W){1'b0}}, req_bus.rect_height});
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in   = ST_SCAN;
                     rd_en      = 1'b1;
                     rd_addr    = '0;
                     cmp_idx_in = '0;
                  end
               end
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the entry at cmp_idx_ff
            if (side != SIDE_NONE) begin
               res_side_in = side;
               res_rect_in = rd_data_ff;
               state_in    = ST_DONE;
            end else if (last_entry) begin
               state_in = ST_DONE;
            end else begin
               rd_en      = 1'b1;
               cmp_idx_in = cmp_idx_ff + RECT_IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_mem[count_ff[RECT_IDX_W-1:0]] <= req_rect;
      end
      if (rd_en) begin
         rd_data_ff <= rect_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      query_ff    <= query_in;
      res_side_ff <= res_side_in;
      res_rect_ff <= res_rect_in;
      res_drop_ff <= res_drop_in;
      if (out_load) begin
         out_side_ff <= res_side_ff;
         out_rect_ff <= res_rect_ff;
         out_drop_ff <= res_drop_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit_side     = out_side_ff;
   assign rsp_bus.match_left   = out_rect_ff.left;
   assign rsp_bus.match_top    = out_rect_ff.top;
   assign rsp_bus.match_width  = out_rect_ff.width;
   assign rsp_bus.match_height = out_rect_ff.height;
   assign rsp_bus.add_dropped  = out_drop_ff;

endmodule

// ===== design/aabb_side_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_side_unit
// Corner-inside tests of the moving box against one stored box, side select.
// ----------------------------------------------------------------------------
module aabb_side_unit (
   input  aabb_pkg::query_type          query,
   input  aabb_pkg::rect_type           entry,
   output logic [aabb_pkg::SIDE_W-1:0]  side
);
   import aabb_pkg::*;

   calc_type l2, t2, r2, b2;
   calc_type dx_r, dy_b, dy_t, dx_l;
   logic     r_in_x, l_in_x, b_in_y, t_in_y;

   always_comb begin
      l2 = {{(CALC_W-COORD_W){entry.left[COORD_W-1]}}, entry.left};
      t2 = {{(CALC_W-COORD_W){entry.top[COORD_W-1]}}, entry.top};
      r2 = l2 + $signed({{(CALC_W-SIZE_W){1'b0}}, entry.width});
      b2 = t2 + $signed({{(CALC_W-SIZE_W){1'b0}}, entry.height});

      r_in_x = (query.right > l2) && (query.right < r2);
      l_in_x = (query.left > l2) && (query.left < r2);
      b_in_y = (query.bottom > t2) && (query.bottom < b2);
      t_in_y = (query.top > t2) && (query.top < b2);

      dx_r = query.right - l2;
      dy_b = query.bottom - t2;
      dy_t = b2 - query.top;
      dx_l = r2 - query.left;

      side = SIDE_NONE;
      if (r_in_x && b_in_y) begin
         side = (dx_r >= dy_b) ? SIDE_TOP : SIDE_LEFT;
      end else if (r_in_x && t_in_y) begin
         side = (dx_r >= dy_t) ? SIDE_BOTTOM : SIDE_LEFT;
      end else if (l_in_x && t_in_y) begin
         side = (dx_l >= dy_t) ? SIDE_BOTTOM : SIDE_RIGHT;
      end else if (l_in_x && b_in_y) begin
         side = (dx_l >= dy_b) ? SIDE_TOP : SIDE_RIGHT;
      end
   end

endmodule
